FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, held off while reset is asserted
`define BDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define BDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bdt_pkg.sv
`timescale 1ns / 1ps

package bdt_pkg;

    // default build sizes
    localparam int NUM_TRACKERS_DEF  = 3;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 8;

    // fixed field widths
    localparam int NUM_REGS   = 3;
    localparam int INTERVAL_W = 22;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int BLK_CNT_W  = 24;
    localparam int MEAN_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int TRACKER_W  = 2;
    localparam int STATUS_W   = 2;

    localparam logic [BLK_CNT_W-1:0] BLK_CNT_MAX = {BLK_CNT_W{1'b1}};
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LONG  = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET [NUM_REGS] =
        '{22'd1000, 22'd10000, 22'd60000};

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_SPREAD_OK  = 2'd0,
        ST_FEW_BLOCKS = 2'd1,
        ST_NO_SAMPLES = 2'd2
    } t_status;

    // output stream layout
    localparam int OUT_TDATA_W = 4 * COUNT_W;
    localparam int OUT_TUSER_W = TRACKER_W + STATUS_W;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: design/bdt_divider.sv
`timescale 1ns / 1ps

module bdt_divider #(
    parameter int DVD_W = bdt_pkg::SAMPLE_BITS_DEF + bdt_pkg::BLK_CNT_W
                        + bdt_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [DVD_W-1:0]         i_dividend,
    input  logic [bdt_pkg::BLK_CNT_W-1:0]   i_divisor,
    output logic [bdt_pkg::MEAN_W-1:0]      o_quotient,
    output bdt_pkg::t_div_stat              o_stat
);
    import bdt_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [BLK_CNT_W-1:0] r_rem;
    logic [BLK_CNT_W-1:0] r_dvs;
    logic [MEAN_W-1:0]    r_quo;
    logic                 r_neg;

    logic [DVD_W-1:0]     w_mag;
    logic [BLK_CNT_W:0]   w_trial;
    logic [BLK_CNT_W:0]   w_sub;
    logic                 w_ge;
    logic [BLK_CNT_W-1:0] n_rem;

    // magnitude of the dividend, quotient sign restored at the end
    assign w_mag = i_dividend[DVD_W-1] ? $unsigned(~i_dividend + 1'b1) : $unsigned(i_dividend);

    // one restoring step: bring down a bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_sub[BLK_CNT_W-1:0] : w_trial[BLK_CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, only the low quotient bits are kept
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd <= w_mag;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[MEAN_W-2:0], w_ge};
        end
    end

    assign o_quotient  = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: design/baseline_drift_tracker_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Block-mean drift tracker for timestamped load-cell samples. An input transfer carries
// op in tuser (0 sample, 1 report) and the reading and millisecond time in tdata. A sample
// visits each tracker in turn and, for every tracker whose block closes on it, waits for
// the block mean, because all block means go one quotient bit per cycle through a single
// shared serial divider. A report gives NUM_TRACKERS result transfers (one when no sample
// has been seen), each loaded into the output register as soon as that register is free.
// The input side is not ready while an item is being worked on; the last result of a
// report may still wait in the output register while the next item is taken. Interval
// registers are written through the configuration channel, which is always ready.
module baseline_drift_tracker_top #(
    parameter int NUM_TRACKERS  = bdt_pkg::NUM_TRACKERS_DEF,
    parameter int SAMPLE_BITS   = bdt_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = bdt_pkg::FRACTION_BITS_DEF,
    localparam int IN_TDATA_W   = ((SAMPLE_BITS + bdt_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]             i_s_axis_tdata,  // reading, time_ms, zero pad
    input  logic                              i_s_axis_tuser,  // op
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bdt_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // spread_q8, block_count,
                                                               // sample_count, elapsed_ms
    output logic [bdt_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,  // tracker, status
    output logic                              o_m_axis_tlast,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bdt_pkg::INTERVAL_W-1:0]    i_cfg_data
);
    import bdt_pkg::*;

    localparam int TRK_W = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
    localparam int SUM_W = SAMPLE_BITS + BLK_CNT_W;
    localparam int DVD_W = SUM_W + FRACTION_BITS;
    localparam logic [TRK_W-1:0] TRK_LAST = TRK_W'(NUM_TRACKERS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // control and item registers
    t_state                   r_state, n_state;
    logic [TRK_W-1:0]         r_trk, n_trk;
    logic                     r_nosamp;
    logic signed [SAMPLE_BITS-1:0] r_reading;
    logic [TIME_W-1:0]        r_time;

    // global tracking state
    logic                     r_started;
    logic [TIME_W-1:0]        r_cap_start;
    logic [COUNT_W-1:0]       r_samples;
    logic [INTERVAL_W-1:0]    r_interval [NUM_REGS];

    // per tracker state
    logic signed [SUM_W-1:0]  r_sum    [NUM_TRACKERS];
    logic [BLK_CNT_W-1:0]     r_cnt    [NUM_TRACKERS];
    logic [TIME_W-1:0]        r_bstart [NUM_TRACKERS];
    logic signed [MEAN_W-1:0] r_min    [NUM_TRACKERS];
    logic signed [MEAN_W-1:0] r_max    [NUM_TRACKERS];
    logic [COUNT_W-1:0]       r_blocks [NUM_TRACKERS];

    // output register
    logic                     r_out_valid;
    logic [TRACKER_W-1:0]     r_out_tracker;
    t_status                  r_out_status;
    logic [COUNT_W-1:0]       r_out_spread;
    logic [COUNT_W-1:0]       r_out_blocks;
    logic [COUNT_W-1:0]       r_out_samples;
    logic [COUNT_W-1:0]       r_out_elapsed;
    logic                     r_out_last;

    logic                     w_in_xfer;
    logic                     w_out_free;
    logic                     w_trk_last;
    logic [INTERVAL_W-1:0]    w_interval;
    logic                     w_cnt_full;
    logic signed [SUM_W-1:0]  w_sum_add;
    logic [BLK_CNT_W-1:0]     w_cnt_add;
    logic [TIME_W-1:0]        w_age;
    logic                     w_close;
    logic                     w_div_start;
    logic signed [DVD_W-1:0]  w_dividend;
    logic signed [MEAN_W-1:0] w_mean;
    t_div_stat                w_div_stat;
    logic                     w_few;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_trk_last      = (r_trk == TRK_LAST);
    assign o_cfg_ready     = 1'b1;

    // interval register for the current tracker, extra trackers share the last one
    always_comb begin
        w_interval = r_interval[NUM_REGS-1];
        for (int k = 0; k < NUM_REGS; k++) begin
            if (int'(r_trk) == k) w_interval = r_interval[k];
        end
    end

    // accumulate the sample and test the block age for the current tracker
    assign w_cnt_full  = (r_cnt[r_trk] == BLK_CNT_MAX);
    assign w_sum_add   = w_cnt_full ? r_sum[r_trk] : r_sum[r_trk] + SUM_W'(r_reading);
    assign w_cnt_add   = w_cnt_full ? r_cnt[r_trk] : r_cnt[r_trk] + 1'b1;
    assign w_age       = r_time - r_bstart[r_trk];
    assign w_close     = (w_age >= TIME_W'(w_interval));
    assign w_div_start = (r_state == S_ADD) && w_close;
    assign w_dividend  = DVD_W'(w_sum_add) <<< FRACTION_BITS;

    bdt_divider #(
        .DVD_W (DVD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_cnt_add),
        .o_quotient (w_mean),
        .o_stat     (w_div_stat)
    );

    assign w_few = (r_blocks[r_trk] < COUNT_W'(2));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_trk   = r_trk;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_trk   = '0;
                    n_state = i_s_axis_tuser ? S_EMIT : S_ADD;
                end
            end
            S_ADD: begin
                if (w_close) begin
                    n_state = S_DIV;
                end else if (w_trk_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_trk = r_trk + 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    if (w_trk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_trk   = r_trk + 1'b1;
                        n_state = S_ADD;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_nosamp || w_trk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_trk = r_trk + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_trk   <= '0;
        end else begin
            r_state <= n_state;
            r_trk   <= n_trk;
        end
    end

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_reading <= SAMPLE_BITS'(i_s_axis_tdata[SAMPLE_BITS-1:0]);
            r_time    <= i_s_axis_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS];
            r_nosamp  <= !r_started || (r_samples == '0);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_interval[k] <= INTERVAL_RESET[k];
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INTERVAL_SHORT: r_interval[0] <= i_cfg_data;
                REG_INTERVAL_MID:   r_interval[1] <= i_cfg_data;
                REG_INTERVAL_LONG:  r_interval[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture start, sample counter and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cap_start <= '0;
            r_samples   <= '0;
            for (int k = 0; k < NUM_TRACKERS; k++) begin
                r_sum[k]    <= '0;
                r_cnt[k]    <= '0;
                r_bstart[k] <= '0;
                r_min[k]    <= '0;
                r_max[k]    <= '0;
                r_blocks[k] <= '0;
            end
        end else begin
            // sample transfer: first one starts capture
            if (w_in_xfer && !i_s_axis_tuser) begin
                if (!r_started) begin
                    r_started   <= 1'b1;
                    r_cap_start <= i_s_axis_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS];
                    for (int k = 0; k < NUM_TRACKERS; k++) begin
                        r_sum[k]    <= '0;
                        r_cnt[k]    <= '0;
                        r_bstart[k] <= i_s_axis_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS];
                        r_min[k]    <= '0;
                        r_max[k]    <= '0;
                        r_blocks[k] <= '0;
                    end
                end
                if (r_samples != COUNT_MAX) r_samples <= r_samples + 1'b1;
            end

            // add sample to the current tracker
            if (r_state == S_ADD) begin
                r_sum[r_trk] <= w_sum_add;
                r_cnt[r_trk] <= w_cnt_add;
            end

            // block mean ready: update extremes and restart the block
            if (r_state == S_DIV && w_div_stat.done) begin
                if (r_blocks[r_trk] == '0) begin
                    r_min[r_trk] <= w_mean;
                    r_max[r_trk] <= w_mean;
                end else if (w_mean < r_min[r_trk]) begin
                    r_min[r_trk] <= w_mean;
                end else if (w_mean > r_max[r_trk]) begin
                    r_max[r_trk] <= w_mean;
                end
                if (r_blocks[r_trk] != COUNT_MAX) r_blocks[r_trk] <= r_blocks[r_trk] + 1'b1;
                r_sum[r_trk]    <= '0;
                r_cnt[r_trk]    <= '0;
                r_bstart[r_trk] <= r_time;
            end

            // report result taken: clear the tracker's spread
            if (r_state == S_EMIT && w_out_free && !r_nosamp) begin
                r_min[r_trk]    <= '0;
                r_max[r_trk]    <= '0;
                r_blocks[r_trk] <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            if (r_nosamp) begin
                r_out_tracker <= '0;
                r_out_status  <= ST_NO_SAMPLES;
                r_out_spread  <= '0;
                r_out_blocks  <= '0;
                r_out_samples <= '0;
                r_out_elapsed <= '0;
                r_out_last    <= 1'b1;
            end else begin
                r_out_tracker <= TRACKER_W'(r_trk);
                r_out_status  <= w_few ? ST_FEW_BLOCKS : ST_SPREAD_OK;
                r_out_spread  <= w_few ? '0 : $unsigned(r_max[r_trk] - r_min[r_trk]);
                r_out_blocks  <= r_blocks[r_trk];
                r_out_samples <= r_samples;
                r_out_elapsed <= r_time - r_cap_start;
                r_out_last    <= w_trk_last;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_elapsed, r_out_samples, r_out_blocks, r_out_spread};
    assign o_m_axis_tuser  = {r_out_status, r_out_tracker};
    assign o_m_axis_tlast  = r_out_last;

    // checks
    `BDT_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div_stat.done |-> (r_state == S_DIV), "divider finished outside division phase")
    `BDT_ASSERT(a_div_nonempty, i_clk, i_rst_n, w_div_start |-> (w_cnt_add != '0), "block mean started on an empty block")
    `BDT_ASSERT(a_emit_div_idle, i_clk, i_rst_n, (r_state == S_EMIT) |-> !w_div_stat.busy, "divider busy while reporting")

endmodule
